// ----- rtl/netd_pkg.sv -----
// types, constants and request descriptor shared by the text decoder modules
`default_nettype none

package netd_pkg;

  localparam int unsigned TBL_DEPTH = 128;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  // queue between front and back, power of two
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [3:0]  NIB_W     = 4'd4;
  localparam logic [3:0]  RAW_W     = 4'd8;
  localparam logic [3:0]  ESC_BASE  = 4'd5;
  localparam logic [3:0]  HDR_BITS  = 4'd6;
  localparam logic [15:0] LIMIT_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic {
    OP_STREAM = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_LO   = 2'd0,
    PH_HI   = 2'd1,
    PH_ESC  = 2'd2,
    PH_BITS = 2'd3
  } phase_e;

  // one queued request: a table write or a result to deliver
  typedef struct packed {
    logic              wr;
    logic              tbl;
    kind_e             kind;
    logic [7:0]        val;
    logic [TBL_AW-1:0] idx;
    logic [15:0]       cnt;
    logic              last;
  } desc_t;

endpackage

`default_nettype wire

// ----- rtl/netd_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module netd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/netd_fifo.sv -----
// short request queue between the decode front and the lookup back
`default_nettype none

module netd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  netd_pkg::desc_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output netd_pkg::desc_t pop_data_o,
  output logic            empty_o
);

  import netd_pkg::*;

  desc_t           slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wptr_q, wptr_d;
  logic [Q_AW-1:0] rptr_q, rptr_d;
  logic [Q_AW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("request queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/netd_front.sv -----
// input holding stage, header parse and code extraction, at most one code per cycle, held while the queue is full
`default_nettype none

module netd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,
  input  logic            s_axis_tuser,
  input  logic            s_axis_tlast,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output netd_pkg::desc_t q_data_o
);

  import netd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEC  = 3'b010,
    ST_END  = 3'b100
  } fst_e;

  // holding register
  logic       hv_q;
  op_e        hop_q;
  logic [7:0] hbyte_q;
  logic [6:0] hslot_q;
  logic       hlast_q;

  fst_e        st_q, st_d;
  phase_e      phase_q, phase_d;
  logic [15:0] target_q, target_d;
  logic [15:0] dec_q, dec_d;
  logic [14:0] acc_q, acc_d;
  logic [3:0]  avail_q, avail_d;
  logic [3:0]  cw_q, cw_d;
  logic [3:0]  esc_q, esc_d;
  logic        fin_q, fin_d;
  logic        chk_q, chk_d;
  logic        last_q, last_d;
  logic        stg_v_q, stg_v_d;
  desc_t       stg_q, stg_d;
  logic [15:0] limit_q;

  logic        new_v, flush, rearm, push_req, go, take, s_acc;
  desc_t       new_desc, push_desc, char_desc;
  logic [3:0]  shamt;
  logic [14:0] shifted, cmask, amask, pend;
  logic [7:0]  code;

  assign shamt   = avail_q - cw_q;
  assign shifted = acc_q >> shamt;
  assign cmask   = (15'd1 << cw_q) - 15'd1;
  assign code    = 8'(shifted & cmask);
  assign amask   = (15'd1 << avail_q) - 15'd1;
  assign pend    = acc_q & amask;

  always_comb begin
    char_desc      = '0;
    char_desc.kind = KIND_CHAR;
    char_desc.cnt  = dec_q;
    if (cw_q == RAW_W) begin
      char_desc.val = code;
    end else if (32'(code) < TBL_DEPTH) begin
      char_desc.tbl = 1'b1;
      char_desc.idx = code[TBL_AW-1:0];
    end
  end

  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    target_d  = target_q;
    dec_d     = dec_q;
    acc_d     = acc_q;
    avail_d   = avail_q;
    cw_d      = cw_q;
    esc_d     = esc_q;
    fin_d     = fin_q;
    chk_d     = chk_q;
    last_d    = last_q;
    stg_v_d   = stg_v_q;
    stg_d     = stg_q;
    new_v     = 1'b0;
    new_desc  = '0;
    flush     = 1'b0;
    rearm     = 1'b0;
    push_req  = 1'b0;
    push_desc = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (hv_q) begin
          if (hop_q == OP_LOAD) begin
            if (32'(hslot_q) < TBL_DEPTH) begin
              push_req      = 1'b1;
              push_desc.wr  = 1'b1;
              push_desc.val = hbyte_q;
              push_desc.idx = hslot_q[TBL_AW-1:0];
            end
          end else begin
            unique case (phase_q)
              PH_LO, PH_HI: begin
                if (phase_q == PH_LO) begin
                  target_d[7:0] = hbyte_q;
                  phase_d       = PH_HI;
                end else begin
                  target_d[15:8] = hbyte_q;
                  phase_d        = PH_ESC;
                end
                if (hlast_q) begin
                  new_v         = 1'b1;
                  new_desc.kind = KIND_ERR;
                  new_desc.cnt  = dec_q;
                  last_d        = 1'b1;
                  st_d          = ST_END;
                end
              end
              PH_ESC: begin
                esc_d   = ESC_BASE + {2'b00, hbyte_q[7:6]};
                phase_d = PH_BITS;
                cw_d    = NIB_W;
                acc_d   = {9'd0, hbyte_q[5:0]};
                avail_d = HDR_BITS;
                chk_d   = 1'b1;
                last_d  = hlast_q;
                st_d    = ST_DEC;
              end
              PH_BITS: begin
                if (!fin_q) begin
                  acc_d   = {pend[6:0], hbyte_q};
                  avail_d = 4'(avail_q[2:0]) + 4'd8;
                  last_d  = hlast_q;
                  st_d    = ST_DEC;
                end else if (hlast_q) begin
                  rearm = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_DEC: begin
        if (chk_q) begin
          chk_d = 1'b0;
          if (!fin_q && dec_q == target_q) begin
            new_v         = 1'b1;
            new_desc.kind = KIND_DONE;
            new_desc.cnt  = dec_q;
            fin_d         = 1'b1;
          end
        end else if (!fin_q && avail_q >= cw_q) begin
          avail_d = avail_q - cw_q;
          if (cw_q == NIB_W && code == '0) begin
            cw_d = esc_q;
          end else begin
            if (dec_q < limit_q) begin
              new_v    = 1'b1;
              new_desc = char_desc;
            end
            dec_d = dec_q + 16'd1;
            cw_d  = NIB_W;
            chk_d = (dec_q + 16'd1 == target_q);
          end
        end else if (last_q && !fin_q) begin
          new_v         = 1'b1;
          new_desc.kind = KIND_ERR;
          new_desc.cnt  = dec_q;
          st_d          = ST_END;
        end else begin
          flush = 1'b1;
          rearm = last_q;
          st_d  = ST_IDLE;
        end
      end
      ST_END: begin
        flush = 1'b1;
        rearm = last_q;
        st_d  = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase

    // one result stays staged so the last one of a byte can be marked
    if (new_v) begin
      if (stg_v_q) begin
        push_req  = 1'b1;
        push_desc = stg_q;
      end
      stg_d   = new_desc;
      stg_v_d = 1'b1;
    end else if (flush && stg_v_q) begin
      push_req       = 1'b1;
      push_desc      = stg_q;
      push_desc.last = 1'b1;
      stg_v_d        = 1'b0;
    end

    if (rearm) begin
      phase_d = PH_LO;
      dec_d   = '0;
      avail_d = '0;
      cw_d    = NIB_W;
      fin_d   = 1'b0;
      chk_d   = 1'b0;
    end
  end

  assign go            = !(push_req && q_full_i);
  assign take          = (st_q == ST_IDLE) && hv_q && go;
  assign s_axis_tready = !hv_q || take;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign q_push_o      = push_req && go;
  assign q_data_o      = push_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q     <= 1'b0;
      st_q     <= ST_IDLE;
      phase_q  <= PH_LO;
      target_q <= '0;
      dec_q    <= '0;
      acc_q    <= '0;
      avail_q  <= '0;
      cw_q     <= NIB_W;
      esc_q    <= ESC_BASE;
      fin_q    <= 1'b0;
      chk_q    <= 1'b0;
      last_q   <= 1'b0;
      stg_v_q  <= 1'b0;
      limit_q  <= LIMIT_RST;
    end else begin
      if (s_acc) begin
        hv_q <= 1'b1;
      end else if (take) begin
        hv_q <= 1'b0;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (go) begin
        st_q     <= st_d;
        phase_q  <= phase_d;
        target_q <= target_d;
        dec_q    <= dec_d;
        acc_q    <= acc_d;
        avail_q  <= avail_d;
        cw_q     <= cw_d;
        esc_q    <= esc_d;
        fin_q    <= fin_d;
        chk_q    <= chk_d;
        last_q   <= last_d;
        stg_v_q  <= stg_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      hop_q   <= op_e'(s_axis_tuser);
      hbyte_q <= s_axis_tdata[7:0];
      hslot_q <= s_axis_tdata[14:8];
      hlast_q <= s_axis_tlast;
    end
    if (go) begin
      stg_q <= stg_d;
    end
  end

  a_idle_unstaged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !stg_v_q)
    else $error("staged result left behind at byte boundary");

  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (dec_q == target_q))
    else $error("string marked complete with count off target");

  a_wide_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw_q != NIB_W) |-> (cw_q == esc_q))
    else $error("code width neither nibble nor escape width");

endmodule

`default_nettype wire

// ----- rtl/netd_back.sv -----
// symbol table, lookup and registered result output
`default_nettype none

module netd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  netd_pkg::desc_t q_data_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,
  output logic [1:0]      m_axis_tuser,
  output logic            m_axis_tlast
);

  import netd_pkg::*;

  logic        p_v_q;
  desc_t       p_q;
  logic        o_v_q;
  logic [23:0] o_data_q;
  kind_e       o_kind_q;
  logic        o_last_q;
  logic        o_load, p_adv;
  logic [7:0]  rdata;

  assign o_load  = !o_v_q || m_axis_tready;
  assign p_adv   = !p_v_q || o_load;
  assign q_pop_o = !q_empty_i && p_adv;

  netd_ram #(
    .WIDTH(8),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (q_pop_o && q_data_i.wr),
    .re_i   (q_pop_o && !q_data_i.wr && q_data_i.tbl),
    .addr_i (q_data_i.idx),
    .wdata_i(q_data_i.val),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (p_adv) begin
        p_v_q <= q_pop_o && !q_data_i.wr;
      end
      if (o_load) begin
        o_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      p_q <= q_data_i;
    end
    if (o_load && p_v_q) begin
      o_data_q <= {p_q.cnt, (p_q.tbl ? rdata : p_q.val)};
      o_kind_q <= p_q.kind;
      o_last_q <= p_q.last;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire

// ----- rtl/nibble_escape_text_decoder.sv -----
// top level of the nibble-escape text decoder
//
// channel   dir  tdata (low bit up)                   tuser        tlast
// s_axis    in   data_byte[7:0], table_slot[14:8], 0  opcode       last_byte
// m_axis    out  char_value[7:0], char_count[23:8]    kind[1:0]    final_res
// cfg       in   cfg_wdata_i = char_limit, written on cfg_we_i
//
// a table load, a count byte or a byte after completion is taken by the front
// in its idle state; a decoding byte enters the decode loop, which takes its
// codes one at a time (escape prefix included), checks the count after the
// escape-width byte and after the character that meets the count, and then
// closes, also after an error on a short stream
// the next byte waits in the holding register while the current one decodes
// results leave through a 4-deep queue, table lookup and an output register,
// one per cycle; a stalled output fills the queue and then holds the front
// reset clears control state only; the symbol table is undefined until loaded
`default_nettype none

module nibble_escape_text_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte, table_slot, zero pad
  input  logic        s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // char_value, char_count
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  import netd_pkg::*;

  logic  push, full, pop, empty;
  desc_t push_data, pop_data;

  netd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_data_o     (push_data)
  );

  netd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  netd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_data_i     (pop_data),
    .q_pop_o      (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire
